// ----- src/lzd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzd_pkg: shared definitions for the LZ77 stream decoder
// Widths, default sizes and the command word passed from front to back end.
// ----------------------------------------------------------------------------
`default_nettype none

package lzd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned POS_W       = 11;
  localparam int unsigned MAX_LEN     = 31;
  localparam int unsigned HIST_DEPTH  = 2048;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Work to be carried out by the back end
  typedef enum logic [1:0] {
    OP_LIT   = 2'd0,  // emit and append one literal byte
    OP_MATCH = 2'd1,  // copy len bytes out of the window
    OP_CLEAR = 2'd2   // empty the window, no output
  } lzd_op_e;

  typedef struct packed {
    lzd_op_e              op;
    logic [POS_W-1:0]     arg;  // literal byte in the low bits, or window position
    logic [LEN_W-1:0]     len;
    logic                 clr;  // empty the window once this command is done
  } lzd_cmd_t;

endpackage

`default_nettype wire

// ----- src/lzd_if.sv -----
// ----------------------------------------------------------------------------
// lzd_if: valid/ready channels of the LZ77 stream decoder
// Compressed input words and decoded output words.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzd_in_if;
  logic                      valid;
  logic                      ready;
  logic [lzd_pkg::BYTE_W-1:0] in_byte;
  logic                      stream_end;

  modport source (output valid, in_byte, stream_end, input ready);
  modport sink   (input valid, in_byte, stream_end, output ready);
endinterface

interface lzd_out_if;
  logic                      valid;
  logic                      ready;
  logic [lzd_pkg::BYTE_W-1:0] out_byte;
  logic                      run_last;

  modport source (output valid, out_byte, run_last, input ready);
  modport sink   (input valid, out_byte, run_last, output ready);
endinterface

`default_nettype wire

// ----- src/lz77_stream_decoder_core.sv -----
// Flow: a literal passes the command queue into the registered output word; match
//   bytes pass a window read into it, one byte per cycle unless the output stalls.
// Stalls: the parser takes words while the queue is not full; a match of length L
//   keeps the window engine busy for L window reads, then L appends unless clr is set.
// Reset: asynchronous, active low; clears control state and the window fill count, so the
//   window reads as all zero at once. Window RAM contents themselves are not swept.
// ----------------------------------------------------------------------------
// lz77_stream_decoder_core: LZ77 stream decoder, 2048-byte window
// Token parser, command queue and window engine with a registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module lz77_stream_decoder_core #(
  // window size in bytes; sets the RAM depth and the pointer widths
  parameter int unsigned HistDepth = lzd_pkg::HIST_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lzd_in_if.sink    in_i,
  lzd_out_if.source out_o
);
  import lzd_pkg::*;

  // Front end: parse tokens and turn each complete item into one command.
  // A zero token followed by a byte becomes a literal command; a nonzero token
  // and its low byte a match command (dropped when length is zero), then a literal
  // one. Stream end folds a window clear into the command, or sends a clear alone.
  lzd_cmd_t push_cmd, head_cmd;
  logic     push, full, head_valid, pop;

  lzd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_full_i (full),
    .cmd_push_o (push),
    .cmd_o      (push_cmd)
  );

  // Queue: let the parser keep taking words while a long match is copied out.
  lzd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  // Back end: read the window for matches, hold the copied bytes in a small
  // buffer, then append them; literals go straight out and into the window.
  lzd_back #(
    .Depth (HistDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ----- src/lzd_ram.sv -----
// ----------------------------------------------------------------------------
// lzd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/lzd_front.sv -----
// ----------------------------------------------------------------------------
// lzd_front: token parser
// Accepts compressed words, tracks the token state and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_front (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lzd_in_if.sink        in_i,
  input  wire logic     cmd_full_i,
  output logic          cmd_push_o,
  output lzd_pkg::lzd_cmd_t cmd_o
);
  import lzd_pkg::*;

  localparam logic [1:0] MODE_TOKEN     = 2'd0;
  localparam logic [1:0] MODE_LIT_PLAIN = 2'd1;
  localparam logic [1:0] MODE_LOW_BYTE  = 2'd2;
  localparam logic [1:0] MODE_LIT_MATCH = 2'd3;

  logic [1:0]       mode_q, mode_d;
  logic [LEN_W-1:0] plen_q, plen_d;
  logic [2:0]       phigh_q, phigh_d;
  logic             accept;

  assign in_i.ready = !cmd_full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    mode_d     = mode_q;
    plen_d     = plen_q;
    phigh_d    = phigh_q;
    cmd_push_o = 1'b0;
    cmd_o.op   = OP_CLEAR;
    cmd_o.arg  = POS_W'(in_i.in_byte);
    cmd_o.len  = plen_q;
    cmd_o.clr  = in_i.stream_end;
    if (accept) begin
      unique case (mode_q)
        MODE_TOKEN: begin
          if (in_i.stream_end) begin
            // drop the incomplete token, empty the window
            cmd_push_o = 1'b1;
          end else if (in_i.in_byte == '0) begin
            mode_d = MODE_LIT_PLAIN;
          end else begin
            plen_d  = in_i.in_byte[7:3];
            phigh_d = in_i.in_byte[2:0];
            mode_d  = MODE_LOW_BYTE;
          end
        end
        MODE_LOW_BYTE: begin
          cmd_o.arg = {phigh_q, in_i.in_byte};
          if (plen_q != '0) begin
            cmd_o.op   = OP_MATCH;
            cmd_push_o = 1'b1;
          end else if (in_i.stream_end) begin
            cmd_push_o = 1'b1;
          end
          mode_d = MODE_LIT_MATCH;
        end
        MODE_LIT_PLAIN, MODE_LIT_MATCH: begin
          cmd_o.op   = OP_LIT;
          cmd_push_o = 1'b1;
          mode_d     = MODE_TOKEN;
        end
        default: mode_d = MODE_TOKEN;
      endcase
      if (in_i.stream_end) begin
        mode_d  = MODE_TOKEN;
        plen_d  = '0;
        phigh_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TOKEN;
      plen_q  <= '0;
      phigh_q <= '0;
    end else begin
      mode_q  <= mode_d;
      plen_q  <= plen_d;
      phigh_q <= phigh_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/lzd_fifo.sv -----
// ----------------------------------------------------------------------------
// lzd_fifo: command queue
// Short register queue between the token parser and the window engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lzd_pkg::lzd_cmd_t cmd_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output lzd_pkg::lzd_cmd_t      cmd_o
);
  import lzd_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  lzd_cmd_t      slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;
  logic          do_push, do_pop;

  assign full_o  = count_q == (PW+1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (PW+1)'(1);
        2'b01:   count_q <= count_q - (PW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/lzd_back.sv -----
// ----------------------------------------------------------------------------
// lzd_back: window engine
// Runs literal, match and clear commands against the history window.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_back #(
  parameter int unsigned Depth = lzd_pkg::HIST_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire lzd_pkg::lzd_cmd_t cmd_i,
  output logic                   cmd_pop_o,
  lzd_out_if.source              out_o
);
  import lzd_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned FW = AW + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     oldest_q, oldest_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              clr_q, clr_d;
  logic [LEN_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic              pend_q, pend_d;
  logic              pend_zero_q, pend_last_q;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic [BYTE_W-1:0] buf_q [MAX_LEN];

  logic              out_free, out_load, move, rd_issue, rd_zero, rd_last;
  logic              full, push, clear;
  logic [AW-1:0]     rd_log, rd_addr, push_addr;
  logic [BYTE_W-1:0] push_data, ram_rdata, move_byte;

  assign out_free  = !out_valid_q || out_o.ready;
  assign move      = pend_q && out_free;
  assign rd_issue  = (state_q == ST_READ) && (rd_cnt_q < len_q) && (!pend_q || move);
  // window position wraps at the depth
  assign rd_log    = AW'(pos_q) + AW'(rd_cnt_q);
  assign rd_addr   = oldest_q + rd_log;
  // never-written slots read as zero
  assign rd_zero   = {1'b0, rd_log} >= fill_q;
  assign rd_last   = rd_cnt_q == (len_q - LEN_W'(1));
  assign full      = fill_q == FW'(Depth);
  assign push_addr = full ? oldest_q : fill_q[AW-1:0];
  assign move_byte = pend_zero_q ? '0 : ram_rdata;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pos_d       = pos_q;
    clr_d       = clr_q;
    rd_cnt_d    = rd_cnt_q;
    idx_d       = idx_q;
    cmd_pop_o   = 1'b0;
    out_load    = 1'b0;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    push        = 1'b0;
    push_data   = buf_q[idx_q];
    clear       = 1'b0;
    pend_d      = rd_issue ? 1'b1 : (move ? 1'b0 : pend_q);
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_LIT: begin
              if (out_free) begin
                cmd_pop_o  = 1'b1;
                out_load   = 1'b1;
                out_byte_d = cmd_i.arg[BYTE_W-1:0];
                out_last_d = 1'b1;
                push_data  = cmd_i.arg[BYTE_W-1:0];
                clear      = cmd_i.clr;
                push       = !cmd_i.clr;
              end
            end
            OP_MATCH: begin
              cmd_pop_o = 1'b1;
              len_d     = cmd_i.len;
              pos_d     = cmd_i.arg;
              clr_d     = cmd_i.clr;
              rd_cnt_d  = '0;
              idx_d     = '0;
              state_d   = ST_READ;
            end
            OP_CLEAR: begin
              cmd_pop_o = 1'b1;
              clear     = 1'b1;
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        if (rd_issue) begin
          rd_cnt_d = rd_cnt_q + LEN_W'(1);
        end
        if (move) begin
          out_load   = 1'b1;
          out_byte_d = move_byte;
          out_last_d = pend_last_q;
          idx_d      = idx_q + LEN_W'(1);
          if (pend_last_q) begin
            // append only after every read has seen the old window
            idx_d = '0;
            if (clr_q) begin
              clear   = 1'b1;
              state_d = ST_IDLE;
            end else begin
              state_d = ST_WRITE;
            end
          end
        end
      end
      ST_WRITE: begin
        push  = 1'b1;
        idx_d = idx_q + LEN_W'(1);
        if (idx_q == (len_q - LEN_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    fill_d   = fill_q;
    oldest_d = oldest_q;
    if (clear) begin
      fill_d   = '0;
      oldest_d = '0;
    end else if (push) begin
      if (full) begin
        oldest_d = oldest_q + AW'(1);
      end else begin
        fill_d = fill_q + FW'(1);
      end
    end
    out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  lzd_ram #(
    .Width (BYTE_W),
    .Depth (Depth)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (push_addr),
    .wdata_i (push_data),
    .re_i    (rd_issue),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (move) begin
      buf_q[idx_q] <= move_byte;
    end
    if (rd_issue) begin
      pend_zero_q <= rd_zero;
      pend_last_q <= rd_last;
    end
    if (out_load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
    end
    len_q <= len_d;
    pos_q <= pos_d;
    clr_q <= clr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      oldest_q    <= '0;
      rd_cnt_q    <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      rd_cnt_q    <= rd_cnt_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.run_last = out_last_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(Depth))
    else $error("window fill count beyond depth");

  a_oldest_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oldest_q != '0) |-> full)
    else $error("oldest pointer moved before window was full");

  a_read_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !out_free) |-> (!rd_issue ##1 pend_q))
    else $error("pending window data overrun");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> (!pend_q && (idx_q < len_q)))
    else $error("append phase out of range or with reads in flight");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (cmd_valid_i && state_q == ST_IDLE))
    else $error("command taken outside idle or from empty queue");

endmodule

`default_nettype wire
